// ===== hw/rtl/fkp_pkg.sv =====
// shared types, constants and helper functions of the five-joint pose block
`timescale 1ns / 1ps
`default_nettype none
package fkp_pkg;

  localparam int unsigned JointCount     = 5;
  localparam int unsigned AtanEntries    = 24;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned LenW           = 22;
  localparam int unsigned AngW           = 16;
  localparam int unsigned PosW           = 24;
  localparam int unsigned MW             = 16;
  localparam int unsigned AccW           = 28;
  localparam int unsigned RotW           = 34;
  localparam int unsigned VecW           = 36;
  localparam int unsigned RadW           = 32;
  localparam int unsigned RootW          = 16;
  localparam int unsigned RemW           = 18;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned AtanInW        = 17;

  typedef logic signed [MW-1:0]   mterm_t;
  typedef logic signed [AngW-1:0] ang_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [RotW-1:0] rot_t;
  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [PosW-1:0] pos_t;
  typedef logic [LenW-1:0]        len_t;
  typedef logic signed [AtanInW-1:0] atin_t;

  localparam rot_t   GainQ30 = 34'sd652032874;
  localparam mterm_t OneQ14  = 16'sd16384;
  localparam mterm_t ZeroQ14 = 16'sd0;

  localparam logic [AngW-1:0] AngQuarter    = 16'h4000;
  localparam logic [AngW-1:0] AngNegQuarter = 16'hC000;
  localparam logic [AngW-1:0] AngHalf       = 16'h8000;
  localparam logic [AngW-1:0] AngZero       = 16'h0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINK0 = 3'd0,
    REG_LINK1 = 3'd1,
    REG_LINK2 = 3'd2,
    REG_LINK3 = 3'd3,
    REG_LINK4 = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    AXIS_Z = 1'b0,
    AXIS_Y = 1'b1
  } axis_e;

  typedef struct packed {
    mterm_t c;
    mterm_t s;
  } sc_t;

  typedef struct packed {
    logic            spec;
    logic [AngW-1:0] sval;
    vec_t            x;
    vec_t            y;
    logic [31:0]     z;
  } vprep_t;

  function automatic axis_e joint_axis(input int unsigned j);
    case (j)
      1, 2, 4: return AXIS_Y;
      default: return AXIS_Z;
    endcase
  endfunction

  function automatic len_t link_reset(input int unsigned j);
    case (j)
      0:       return 22'd17024;
      1:       return 22'd85965;
      2:       return 22'd46848;
      3:       return 22'd14080;
      default: return 22'd17920;
    endcase
  endfunction

  function automatic logic [31:0] atan_entry(input int unsigned i);
    case (i)
      0:       return 32'h20000000;
      1:       return 32'h12E4051E;
      2:       return 32'h09FB385B;
      3:       return 32'h051111D4;
      4:       return 32'h028B0D43;
      5:       return 32'h0145D7E1;
      6:       return 32'h00A2F61E;
      7:       return 32'h00517C55;
      8:       return 32'h0028BE53;
      9:       return 32'h00145F2F;
      10:      return 32'h000A2F98;
      11:      return 32'h000517CC;
      12:      return 32'h00028BE6;
      13:      return 32'h000145F3;
      14:      return 32'h0000A2FA;
      15:      return 32'h0000517D;
      16:      return 32'h000028BE;
      17:      return 32'h0000145F;
      18:      return 32'h00000A30;
      19:      return 32'h00000518;
      20:      return 32'h0000028C;
      21:      return 32'h00000146;
      22:      return 32'h000000A3;
      23:      return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

  // round half up by 2^14 and saturate to a matrix term
  function automatic mterm_t rnd_q14(input logic signed [2*MW:0] v);
    logic signed [2*MW:0] t;
    t = (v + 33'sd8192) >>> 14;
    if (t > 33'sd32767) return 16'sd32767;
    if (t < -33'sd32768) return -16'sd32768;
    return mterm_t'(t);
  endfunction

  // q30 cordic output to q2.14, clamped to plus or minus one
  function automatic mterm_t cs_round(input rot_t v);
    rot_t t;
    t = (v + 34'sd32768) >>> 16;
    if (t > 34'sd16384) return OneQ14;
    if (t < -34'sd16384) return -OneQ14;
    return mterm_t'(t);
  endfunction

  function automatic pos_t sat_pos(input acc_t v);
    if (v > 28'sd8388607) return 24'sd8388607;
    if (v < -28'sd8388608) return -24'sd8388608;
    return pos_t'(v);
  endfunction

  // axis cases, scaling and quadrant pre-rotation ahead of the vectoring chain
  function automatic vprep_t vec_prep(input atin_t y, input atin_t x);
    vprep_t r;
    vec_t   xs;
    vec_t   ys;
    xs = vec_t'(x) <<< 14;
    ys = vec_t'(y) <<< 14;
    r.spec = (x == 0) || (y == 0);
    if (x == 0) begin
      r.sval = (y > 0) ? AngQuarter : ((y < 0) ? AngNegQuarter : AngZero);
    end else begin
      r.sval = (x > 0) ? AngZero : AngHalf;
    end
    r.x = xs;
    r.y = ys;
    r.z = 32'h0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = ys;
        r.y = -xs;
        r.z = 32'h40000000;
      end else begin
        r.x = -ys;
        r.y = xs;
        r.z = 32'hC0000000;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fkp_rot_cell.sv =====
// one rotation-mode cordic step with its output register
`timescale 1ns / 1ps
`default_nettype none
module fkp_rot_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic          clk_i,
  input  fkp_pkg::rot_t x_i,
  input  fkp_pkg::rot_t y_i,
  input  fkp_pkg::rot_t z_i,
  output fkp_pkg::rot_t x_o,
  output fkp_pkg::rot_t y_o,
  output fkp_pkg::rot_t z_o
);
  import fkp_pkg::*;

  rot_t dx, dy, da;
  rot_t x_d, y_d, z_d;
  rot_t x_q, y_q, z_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;
  assign da = rot_t'({{(RotW-32){1'b0}}, atan_entry(STEP)});

  always_comb begin
    if (!z_i[RotW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - da;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + da;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule
`default_nettype wire

// ===== hw/rtl/fkp_vec_cell.sv =====
// one vectoring-mode cordic step with its output register
`timescale 1ns / 1ps
`default_nettype none
module fkp_vec_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic          clk_i,
  input  fkp_pkg::vec_t x_i,
  input  fkp_pkg::vec_t y_i,
  input  logic [31:0]   z_i,
  output fkp_pkg::vec_t x_o,
  output fkp_pkg::vec_t y_o,
  output logic [31:0]   z_o
);
  import fkp_pkg::*;

  vec_t        dx, dy;
  vec_t        x_d, y_d, x_q, y_q;
  logic [31:0] z_d, z_q;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (!y_i[VecW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_entry(STEP);
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_entry(STEP);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule
`default_nettype wire

// ===== hw/rtl/fkp_sqrt_cell.sv =====
// one restoring square-root digit with its output register
`timescale 1ns / 1ps
`default_nettype none
module fkp_sqrt_cell #(
  parameter int unsigned BITPOS = 15
) (
  input  logic                      clk_i,
  input  logic [fkp_pkg::RadW-1:0]  rad_i,
  input  logic [fkp_pkg::RemW-1:0]  rem_i,
  input  logic [fkp_pkg::RootW-1:0] root_i,
  output logic [fkp_pkg::RadW-1:0]  rad_o,
  output logic [fkp_pkg::RemW-1:0]  rem_o,
  output logic [fkp_pkg::RootW-1:0] root_o
);
  import fkp_pkg::*;

  logic [RemW+1:0]  cur;
  logic [RemW+1:0]  trial;
  logic [RemW-1:0]  rem_d, rem_q;
  logic [RootW-1:0] root_d, root_q;
  logic [RadW-1:0]  rad_q;

  assign cur   = {rem_i, rad_i[2*BITPOS+1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};

  always_comb begin
    if (cur >= trial) begin
      rem_d  = RemW'(cur - trial);
      root_d = {root_i[RootW-2:0], 1'b1};
    end else begin
      rem_d  = cur[RemW-1:0];
      root_d = {root_i[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_i;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

// ===== hw/rtl/fkp_joint_cell.sv =====
// one joint of the chain: rotate the matrix columns, then advance the position
`timescale 1ns / 1ps
`default_nettype none
module fkp_joint_cell #(
  parameter int unsigned J = 0
) (
  input  logic            clk_i,
  input  fkp_pkg::mterm_t m_i  [9],
  input  fkp_pkg::acc_t   p_i  [3],
  input  fkp_pkg::sc_t    sc_i [fkp_pkg::JointCount],
  input  fkp_pkg::len_t   len_i,
  output fkp_pkg::mterm_t m_o  [9],
  output fkp_pkg::acc_t   p_o  [3],
  output fkp_pkg::sc_t    sc_o [fkp_pkg::JointCount]
);
  import fkp_pkg::*;

  localparam axis_e Axis = joint_axis(J);
  // column that pairs with column 0
  localparam int unsigned K = (Axis == AXIS_Y) ? 2 : 1;

  typedef logic signed [2*MW-1:0]  prod_t;
  typedef logic signed [MW+LenW:0] lprod_t;

  mterm_t c, s;
  prod_t  pa_q [3], pb_q [3], pc_q [3], pd_q [3];
  mterm_t m1_q [9], m2_q [9], m3_q [9], m4_q [9];
  mterm_t m2_d [9];
  acc_t   p1_q [3], p2_q [3], p3_q [3], p4_q [3];
  sc_t    sc1_q [JointCount], sc2_q [JointCount], sc3_q [JointCount], sc4_q [JointCount];
  lprod_t q_q  [3];
  logic signed [2*MW:0] s0 [3], sk [3];

  assign c = sc_i[J].c;
  assign s = sc_i[J].s;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (Axis == AXIS_Y) begin
        s0[r] = pa_q[r] - pb_q[r];
        sk[r] = pd_q[r] + pc_q[r];
      end else begin
        s0[r] = pa_q[r] + pb_q[r];
        sk[r] = pc_q[r] - pd_q[r];
      end
    end
  end

  // rounded new columns, the remaining column passes through
  always_comb begin
    m2_d = m1_q;
    for (int r = 0; r < 3; r++) begin
      m2_d[r*3]   = rnd_q14(s0[r]);
      m2_d[r*3+K] = rnd_q14(sk[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    // rotation products
    for (int r = 0; r < 3; r++) begin
      pa_q[r] <= c * m_i[r*3];
      pb_q[r] <= s * m_i[r*3+K];
      pc_q[r] <= c * m_i[r*3+K];
      pd_q[r] <= s * m_i[r*3];
    end
    m1_q  <= m_i;
    p1_q  <= p_i;
    sc1_q <= sc_i;
    m2_q  <= m2_d;
    p2_q  <= p1_q;
    sc2_q <= sc1_q;
    // link offset along the new z column
    for (int r = 0; r < 3; r++) begin
      q_q[r] <= m2_q[r*3+2] * $signed({1'b0, len_i});
    end
    m3_q  <= m2_q;
    p3_q  <= p2_q;
    sc3_q <= sc2_q;
    // position accumulate
    for (int r = 0; r < 3; r++) begin
      p4_q[r] <= p3_q[r] + acc_t'((q_q[r] + lprod_t'(8192)) >>> 14);
    end
    m4_q  <= m3_q;
    sc4_q <= sc3_q;
  end

  assign m_o  = m4_q;
  assign p_o  = p4_q;
  assign sc_o = sc4_q;
endmodule
`default_nettype wire

// ===== hw/rtl/forward_kinematics_5dof_pose.sv =====
// top level: five-joint forward kinematics, joint angles in, end pose out
`timescale 1ns / 1ps
`default_nettype none
// Takes one set of five joint angles per clock and returns the end position and the
// pitch, roll and yaw of the tool. The block is a pure pipeline: busy never rises and
// start may be held high every cycle. Each request comes back on done_o in the order
// it was taken. The pipe holds the two cordic chains (sine/cosine and atan2, one step
// per stage), the four stages of each of the five joints and the sixteen square-root
// digit stages. Results show for one cycle only and there is no back-pressure, so the
// receiver must take them as they come. Link lengths are written through cfg_we_i/
// cfg_idx_i/cfg_data_i and are read live by the joints, so write them only when no
// request is in flight.
module forward_kinematics_5dof_pose #(
  parameter int unsigned CORDIC_STEPS = fkp_pkg::CordicStepsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fkp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fkp_pkg::LenW-1:0]    cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  fkp_pkg::ang_t               joint0_angle_i,
  input  fkp_pkg::ang_t               joint1_angle_i,
  input  fkp_pkg::ang_t               joint2_angle_i,
  input  fkp_pkg::ang_t               joint3_angle_i,
  input  fkp_pkg::ang_t               joint4_angle_i,
  output logic                        done_o,
  output fkp_pkg::pos_t               pos_x_o,
  output fkp_pkg::pos_t               pos_y_o,
  output fkp_pkg::pos_t               pos_z_o,
  output fkp_pkg::ang_t               pitch_angle_o,
  output fkp_pkg::ang_t               roll_angle_o,
  output fkp_pkg::ang_t               yaw_angle_o,
  output logic                        gimbal_degenerate_o
);
  import fkp_pkg::*;

  // steps beyond the arctangent table are not used
  localparam int unsigned N   = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam int unsigned Lat = 2*N + 41;
  localparam int unsigned NumAt = 4;
  // atan2 chain slots
  localparam int unsigned AtPitch = 0;
  localparam int unsigned AtRoll  = 1;
  localparam int unsigned AtYaw   = 2;
  localparam int unsigned AtAlt   = 3;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // link length registers
  len_t link_q [JointCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < JointCount; j++) link_q[j] <= link_reset(j);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LINK0: link_q[0] <= cfg_data_i;
        REG_LINK1: link_q[1] <= cfg_data_i;
        REG_LINK2: link_q[2] <= cfg_data_i;
        REG_LINK3: link_q[3] <= cfg_data_i;
        REG_LINK4: link_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request strobe follows the data through the pipe
  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  assign done_o = vld_q[Lat-1];

  // input stage: fold the angle into the right half plane, keep the flip
  ang_t ang [JointCount];
  assign ang[0] = joint0_angle_i;
  assign ang[1] = joint1_angle_i;
  assign ang[2] = joint2_angle_i;
  assign ang[3] = joint3_angle_i;
  assign ang[4] = joint4_angle_i;

  rot_t zin_q  [JointCount];
  logic flin_q [JointCount];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < JointCount; j++) begin
      logic [AngW-1:0] t;
      logic [AngW-1:0] a;
      t = ang[j] + AngQuarter;
      a = t[AngW-1] ? (ang[j] ^ AngHalf) : ang[j];
      flin_q[j] <= t[AngW-1];
      zin_q[j]  <= rot_t'($signed({a, 16'h0000}));
    end
  end

  // sine/cosine chains, one cell per step
  rot_t rx [JointCount][N];
  rot_t ry [JointCount][N];
  rot_t rz [JointCount][N];
  logic fl_q [JointCount][N];

  for (genvar j = 0; j < JointCount; j++) begin : g_sc
    for (genvar g = 0; g < N; g++) begin : g_step
      if (g == 0) begin : g_first
        fkp_rot_cell #(.STEP(g)) u_cell (
          .clk_i (clk_i),
          .x_i   (GainQ30),
          .y_i   ('0),
          .z_i   (zin_q[j]),
          .x_o   (rx[j][g]),
          .y_o   (ry[j][g]),
          .z_o   (rz[j][g])
        );
        always_ff @(posedge clk_i) fl_q[j][g] <= flin_q[j];
      end else begin : g_next
        fkp_rot_cell #(.STEP(g)) u_cell (
          .clk_i (clk_i),
          .x_i   (rx[j][g-1]),
          .y_i   (ry[j][g-1]),
          .z_i   (rz[j][g-1]),
          .x_o   (rx[j][g]),
          .y_o   (ry[j][g]),
          .z_o   (rz[j][g])
        );
        always_ff @(posedge clk_i) fl_q[j][g] <= fl_q[j][g-1];
      end
    end
  end

  // round to q2.14 and undo the half-turn fold
  sc_t sc_q [JointCount];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < JointCount; j++) begin
      mterm_t c;
      mterm_t s;
      c = cs_round(rx[j][N-1]);
      s = cs_round(ry[j][N-1]);
      sc_q[j].c <= fl_q[j][N-1] ? -c : c;
      sc_q[j].s <= fl_q[j][N-1] ? -s : s;
    end
  end

  // joint chain, starting from the identity pose
  mterm_t m_id [9];
  acc_t   p_id [3];
  assign m_id = '{OneQ14, ZeroQ14, ZeroQ14,
                  ZeroQ14, OneQ14, ZeroQ14,
                  ZeroQ14, ZeroQ14, OneQ14};
  assign p_id = '{28'sd0, 28'sd0, 28'sd0};

  mterm_t jm  [JointCount][9];
  acc_t   jp  [JointCount][3];
  sc_t    jsc [JointCount][JointCount];

  for (genvar j = 0; j < JointCount; j++) begin : g_joint
    if (j == 0) begin : g_first
      fkp_joint_cell #(.J(j)) u_joint (
        .clk_i (clk_i),
        .m_i   (m_id),
        .p_i   (p_id),
        .sc_i  (sc_q),
        .len_i (link_q[j]),
        .m_o   (jm[j]),
        .p_o   (jp[j]),
        .sc_o  (jsc[j])
      );
    end else begin : g_next
      fkp_joint_cell #(.J(j)) u_joint (
        .clk_i (clk_i),
        .m_i   (jm[j-1]),
        .p_i   (jp[j-1]),
        .sc_i  (jsc[j-1]),
        .len_i (link_q[j]),
        .m_o   (jm[j]),
        .p_o   (jp[j]),
        .sc_o  (jsc[j])
      );
    end
  end

  // squared length of the first column in the xy plane
  logic signed [2*MW-1:0] sq0, sq1;
  logic [RadW-1:0] rad_q;
  mterm_t msq_q [9];
  acc_t   psq_q [3];

  assign sq0 = jm[JointCount-1][0] * jm[JointCount-1][0];
  assign sq1 = jm[JointCount-1][3] * jm[JointCount-1][3];

  always_ff @(posedge clk_i) begin
    rad_q <= RadW'(sq0) + RadW'(sq1);
    msq_q <= jm[JointCount-1];
    psq_q <= jp[JointCount-1];
  end

  // square root, one result bit per cell; pose rides alongside
  logic [RadW-1:0]  srad  [RootW];
  logic [RemW-1:0]  srem  [RootW];
  logic [RootW-1:0] sroot [RootW];
  mterm_t sm_q [RootW][9];
  acc_t   sp_q [RootW][3];

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    if (g == 0) begin : g_first
      fkp_sqrt_cell #(.BITPOS(RootW-1-g)) u_cell (
        .clk_i  (clk_i),
        .rad_i  (rad_q),
        .rem_i  ('0),
        .root_i ('0),
        .rad_o  (srad[g]),
        .rem_o  (srem[g]),
        .root_o (sroot[g])
      );
      always_ff @(posedge clk_i) begin
        sm_q[g] <= msq_q;
        sp_q[g] <= psq_q;
      end
    end else begin : g_next
      fkp_sqrt_cell #(.BITPOS(RootW-1-g)) u_cell (
        .clk_i  (clk_i),
        .rad_i  (srad[g-1]),
        .rem_i  (srem[g-1]),
        .root_i (sroot[g-1]),
        .rad_o  (srad[g]),
        .rem_o  (srem[g]),
        .root_o (sroot[g])
      );
      always_ff @(posedge clk_i) begin
        sm_q[g] <= sm_q[g-1];
        sp_q[g] <= sp_q[g-1];
      end
    end
  end

  // atan2 set-up for pitch, roll, yaw and the degenerate yaw
  mterm_t mf [9];
  assign mf = sm_q[RootW-1];

  atin_t at_y [NumAt];
  atin_t at_x [NumAt];

  assign at_y[AtPitch] = -atin_t'(mf[6]);
  assign at_x[AtPitch] = atin_t'({1'b0, sroot[RootW-1]});
  assign at_y[AtRoll]  = atin_t'(mf[5]);
  assign at_x[AtRoll]  = atin_t'(mf[2]);
  assign at_y[AtYaw]   = atin_t'(mf[1]);
  assign at_x[AtYaw]   = atin_t'(mf[0]);
  assign at_y[AtAlt]   = -atin_t'(mf[3]);
  assign at_x[AtAlt]   = atin_t'(mf[6]);

  vprep_t vp_q [NumAt];
  acc_t   pp_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumAt; k++) vp_q[k] <= vec_prep(at_y[k], at_x[k]);
    pp_q <= sp_q[RootW-1];
  end

  // vectoring chains; axis cases and position ride alongside
  vec_t        vx [NumAt][N];
  vec_t        vy [NumAt][N];
  logic [31:0] vz [NumAt][N];
  logic            spec_q [NumAt][N];
  logic [AngW-1:0] sval_q [NumAt][N];
  acc_t            vp_p_q [N][3];

  for (genvar k = 0; k < NumAt; k++) begin : g_at
    for (genvar g = 0; g < N; g++) begin : g_step
      if (g == 0) begin : g_first
        fkp_vec_cell #(.STEP(g)) u_cell (
          .clk_i (clk_i),
          .x_i   (vp_q[k].x),
          .y_i   (vp_q[k].y),
          .z_i   (vp_q[k].z),
          .x_o   (vx[k][g]),
          .y_o   (vy[k][g]),
          .z_o   (vz[k][g])
        );
        always_ff @(posedge clk_i) begin
          spec_q[k][g] <= vp_q[k].spec;
          sval_q[k][g] <= vp_q[k].sval;
        end
      end else begin : g_next
        fkp_vec_cell #(.STEP(g)) u_cell (
          .clk_i (clk_i),
          .x_i   (vx[k][g-1]),
          .y_i   (vy[k][g-1]),
          .z_i   (vz[k][g-1]),
          .x_o   (vx[k][g]),
          .y_o   (vy[k][g]),
          .z_o   (vz[k][g])
        );
        always_ff @(posedge clk_i) begin
          spec_q[k][g] <= spec_q[k][g-1];
          sval_q[k][g] <= sval_q[k][g-1];
        end
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_pdly
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) vp_p_q[g] <= pp_q;
    end else begin : g_next
      always_ff @(posedge clk_i) vp_p_q[g] <= vp_p_q[g-1];
    end
  end

  // angle rounding, degenerate pitch select, position saturation
  logic [AngW-1:0] at_ang [NumAt];
  logic            degen;

  always_comb begin
    for (int k = 0; k < NumAt; k++) begin
      logic [31:0] zr;
      zr = vz[k][N-1] + 32'h00008000;
      at_ang[k] = spec_q[k][N-1] ? sval_q[k][N-1] : zr[31:16];
    end
  end

  assign degen = (at_ang[AtPitch] == AngQuarter) || (at_ang[AtPitch] == AngNegQuarter);

  pos_t px_q, py_q, pz_q;
  ang_t pitch_q, roll_q, yaw_q;
  logic degen_q;

  always_ff @(posedge clk_i) begin
    px_q    <= sat_pos(vp_p_q[N-1][0]);
    py_q    <= sat_pos(vp_p_q[N-1][1]);
    pz_q    <= sat_pos(vp_p_q[N-1][2]);
    pitch_q <= ang_t'(at_ang[AtPitch]);
    roll_q  <= degen ? ang_t'(AngZero) : ang_t'(at_ang[AtRoll]);
    yaw_q   <= degen ? ang_t'(at_ang[AtAlt]) : ang_t'(at_ang[AtYaw]);
    degen_q <= degen;
  end

  assign pos_x_o             = px_q;
  assign pos_y_o             = py_q;
  assign pos_z_o             = pz_q;
  assign pitch_angle_o       = pitch_q;
  assign roll_angle_o        = roll_q;
  assign yaw_angle_o         = yaw_q;
  assign gimbal_degenerate_o = degen_q;
endmodule
`default_nettype wire

// ===== hw/rtl/fkp_checker.sv =====
// port-level checks on the pose block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fkp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          busy,
  input logic          done_o,
  input fkp_pkg::ang_t pitch_angle_o,
  input fkp_pkg::ang_t roll_angle_o,
  input logic          gimbal_degenerate_o
);
  import fkp_pkg::*;

  // the pipeline takes a request every cycle
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // degenerate results carry a zero roll
  a_degen_roll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && gimbal_degenerate_o |-> roll_angle_o == ang_t'(AngZero))
    else $error("roll not zero on degenerate pitch");

  // flag set only for a vertical pitch
  a_degen_pitch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && gimbal_degenerate_o |->
      (pitch_angle_o == ang_t'(AngQuarter)) || (pitch_angle_o == ang_t'(AngNegQuarter)))
    else $error("degenerate flag with non-vertical pitch");

  // vertical pitch always raises the flag
  a_pitch_degen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ((pitch_angle_o == ang_t'(AngQuarter)) ||
               (pitch_angle_o == ang_t'(AngNegQuarter))) |-> gimbal_degenerate_o)
    else $error("vertical pitch without degenerate flag");
endmodule

bind forward_kinematics_5dof_pose fkp_checker u_fkp_checker (.*);
`default_nettype wire

// ===== dv/forward_kinematics_5dof_pose_tb.sv =====
// self-checking testbench of the five-joint forward kinematics pose block
`timescale 1ns / 1ps
module forward_kinematics_5dof_pose_tb;
  import fkp_pkg::*;

  localparam int unsigned Steps      = 16;
  localparam int unsigned DrainWait  = 2 * Steps + 41 + 10;
  localparam int unsigned StallLimit = 5000;
  localparam longint      LenMax     = 4194303;

  // one set of joint angles waiting to go out
  typedef struct {
    ang_t a [5];
  } joint_set_t;

  // one predicted pose
  typedef struct {
    longint    px;
    longint    py;
    longint    pz;
    bit [15:0] pitch;
    bit [15:0] roll;
    bit [15:0] yaw;
    bit        degen;
  } pose_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [LenW-1:0] cfg_data_i;
  logic start;
  logic busy;
  ang_t joint_i [5];
  logic done_o;
  pos_t pos_x_o, pos_y_o, pos_z_o;
  ang_t pitch_angle_o, roll_angle_o, yaw_angle_o;
  logic gimbal_degenerate_o;

  forward_kinematics_5dof_pose dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .start(start), .busy(busy),
    .joint0_angle_i(joint_i[0]), .joint1_angle_i(joint_i[1]),
    .joint2_angle_i(joint_i[2]), .joint3_angle_i(joint_i[3]),
    .joint4_angle_i(joint_i[4]),
    .done_o(done_o), .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .pos_z_o(pos_z_o),
    .pitch_angle_o(pitch_angle_o), .roll_angle_o(roll_angle_o),
    .yaw_angle_o(yaw_angle_o), .gimbal_degenerate_o(gimbal_degenerate_o)
  );

  // shadow of the link length registers
  longint link_len [5];

  joint_set_t pending_sets [$];
  pose_t      expected_poses [$];
  int unsigned n_taken = 0;
  int unsigned n_popped = 0;
  int unsigned gap_left = 0;
  bit          gaps_on;
  bit          hold_req;
  int unsigned fails = 0;
  int unsigned stall_cnt = 0;

  bit [31:0] arctan_q32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint q14_round(longint v);
    return clip((v + 8192) >>> 14, -32768, 32767);
  endfunction

  // rotation-mode cordic on a 32-bit angle, q2.14 cosine and sine out
  task automatic cos_sin(input bit [31:0] a, output longint c, output longint s);
    bit flip;
    longint x, y, z, dx, dy;
    flip = ((a + 32'h40000000) & 32'h80000000) != 0;
    if (flip) a = a + 32'h80000000;
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'({32'b0, arctan_q32[i]});
      end else begin
        x = x + dx; y = y - dy; z = z + longint'({32'b0, arctan_q32[i]});
      end
    end
    x = clip((x + 32768) >>> 16, -16384, 16384);
    y = clip((y + 32768) >>> 16, -16384, 16384);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // vectoring-mode cordic atan2 to a binary angle
  function automatic bit [15:0] bin_atan2(longint y, longint x);
    bit [31:0] z;
    longint t, dx, dy;
    z = 0;
    if (x == 0) return y > 0 ? 16'h4000 : (y < 0 ? 16'hC000 : 16'h0000);
    if (y == 0) return x > 0 ? 16'h0000 : 16'h8000;
    x = x * 16384;
    y = y * 16384;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 32'h40000000;
      end else begin
        x = -y; y = t; z = 32'hC0000000;
      end
    end
    for (int i = 0; i < Steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + arctan_q32[i];
      end else begin
        x = x - dx; y = y + dy; z = z - arctan_q32[i];
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // chain of five joint rotations and links, then the pose angles
  task automatic predict_pose(input joint_set_t js, output pose_t po);
    longint m [3][3];
    longint p [3];
    longint c, s, a0, a1, a2;
    for (int r = 0; r < 3; r++) begin
      p[r] = 0;
      for (int k = 0; k < 3; k++) m[r][k] = (r == k) ? 16384 : 0;
    end
    for (int j = 0; j < 5; j++) begin
      cos_sin({js.a[j], 16'h0000}, c, s);
      for (int r = 0; r < 3; r++) begin
        a0 = m[r][0];
        if (joint_axis(j) == AXIS_Y) begin
          a2 = m[r][2];
          m[r][0] = q14_round(c * a0 - s * a2);
          m[r][2] = q14_round(s * a0 + c * a2);
        end else begin
          a1 = m[r][1];
          m[r][0] = q14_round(c * a0 + s * a1);
          m[r][1] = q14_round(c * a1 - s * a0);
        end
      end
      for (int r = 0; r < 3; r++) p[r] = p[r] + ((m[r][2] * link_len[j] + 8192) >>> 14);
    end
    po.pitch = bin_atan2(-m[2][0], int_sqrt(m[0][0] * m[0][0] + m[1][0] * m[1][0]));
    if (po.pitch == AngQuarter || po.pitch == AngNegQuarter) begin
      // gimbal lock: roll forced to zero, yaw from the alternate pair
      po.degen = 1;
      po.roll  = 0;
      po.yaw   = bin_atan2(-m[1][0], m[2][0]);
    end else begin
      po.degen = 0;
      po.roll  = bin_atan2(m[1][2], m[0][2]);
      po.yaw   = bin_atan2(m[0][1], m[0][0]);
    end
    po.px = clip(p[0], -8388608, 8388607);
    po.py = clip(p[1], -8388608, 8388607);
    po.pz = clip(p[2], -8388608, 8388607);
  endtask

  task automatic check_field(input string nm, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", nm, exp_v, act_v);
      fails++;
    end
  endtask

  // gap after a request: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: presents the head of the pending queue until it is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      while (n_popped < n_taken) begin
        void'(pending_sets.pop_front());
        n_popped++;
        gap_left = pick_gap();
      end
      if (gap_left > 0 || hold_req || pending_sets.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        for (int j = 0; j < 5; j++) joint_i[j] <= pending_sets[0].a[j];
      end
    end
  end

  // monitor: records requests taken, checks every pose that comes back
  always @(posedge clk_i) begin
    joint_set_t js;
    pose_t      pe;
    pose_t      got;
    bit         progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (start && !busy) begin
        for (int j = 0; j < 5; j++) js.a[j] = joint_i[j];
        predict_pose(js, pe);
        expected_poses = {expected_poses, pe};
        n_taken++;
        progress = 1'b1;
      end
      if (done_o) begin
        progress = 1'b1;
        if (expected_poses.size() == 0) begin
          $error("pose returned with no request outstanding");
          fails++;
        end else begin
          got = expected_poses.pop_front();
          check_field("pos_x", got.px, longint'(pos_x_o));
          check_field("pos_y", got.py, longint'(pos_y_o));
          check_field("pos_z", got.pz, longint'(pos_z_o));
          check_field("pitch_angle", longint'($signed(got.pitch)), longint'(pitch_angle_o));
          check_field("roll_angle", longint'($signed(got.roll)), longint'(roll_angle_o));
          check_field("yaw_angle", longint'($signed(got.yaw)), longint'(yaw_angle_o));
          check_field("gimbal_degenerate", longint'(got.degen),
                      longint'(gimbal_degenerate_o));
        end
      end
      stall_cnt <= progress ? 0 : stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input int unsigned idx, input longint val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[CfgIdxW-1:0];
    cfg_data_i <= val[LenW-1:0];
    if (idx < 5) link_len[idx] = val & LenMax;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_links(input longint l0, l1, l2, l3, l4);
    write_reg(REG_LINK0, l0);
    write_reg(REG_LINK1, l1);
    write_reg(REG_LINK2, l2);
    write_reg(REG_LINK3, l3);
    write_reg(REG_LINK4, l4);
    // unmapped indexes must leave the links alone
    write_reg($urandom_range(5, 7), $urandom_range(0, LenMax));
  endtask

  task automatic queue_set(input ang_t a0, a1, a2, a3, a4);
    joint_set_t js;
    js.a[0] = a0; js.a[1] = a1; js.a[2] = a2; js.a[3] = a3; js.a[4] = a4;
    pending_sets = {pending_sets, js};
  endtask

  // angles spread over the circle, with extra weight on and near multiples of a sixteenth turn
  function automatic ang_t pick_angle();
    case ($urandom_range(0, 3))
      0:       return ang_t'($urandom_range(0, 7) * 8192 + $urandom_range(0, 6) - 3);
      1:       return ang_t'($urandom_range(0, 15) * 4096);
      default: return ang_t'($urandom());
    endcase
  endfunction

  task automatic queue_random(input int unsigned n);
    ang_t a1, a2;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        // pitch lands on a quarter turn: gimbal lock case
        a1 = pick_angle();
        a2 = pick_angle();
        queue_set(pick_angle(), a1, a2, 0,
                  ang_t'(($urandom_range(0, 1) ? 16384 : -16384) - a1 - a2));
      end else begin
        queue_set(pick_angle(), pick_angle(), pick_angle(), pick_angle(), pick_angle());
      end
    end
  endtask

  task automatic drain();
    wait (pending_sets.size() == 0 && expected_poses.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    start      = 1'b0;
    for (int j = 0; j < 5; j++) begin
      joint_i[j] = '0;
      link_len[j] = link_reset(j);
    end
    gaps_on = 1'b0; hold_req = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sets on the reset lengths, back to back
    queue_set(0, 0, 0, 0, 0);
    queue_set(32767, 32767, 32767, 32767, 32767);
    queue_set(-32768, -32768, -32768, -32768, -32768);
    queue_set(16384, 0, 0, 0, 0);
    queue_set(-16384, 0, 0, 0, 0);
    queue_set(0, 16384, 0, 0, 0);
    queue_set(0, -16384, 0, 0, 0);
    queue_set(0, 8192, 8192, 0, 0);
    queue_set(0, 0, 0, 0, 16384);
    queue_set(0, 0, 0, 0, -16384);
    queue_set(0, 0, 0, 16384, 0);
    queue_set(0, -32768, 0, 0, 0);
    queue_set(8192, 8192, -8192, 8192, -8192);
    queue_set(1, -1, 1, -1, 1);
    queue_set(-32768, 16384, 0, 0, 0);
    queue_set(0, 0, -32768, 0, 0);
    queue_set(12345, -23456, 3210, -7777, 30000);
    queue_set(0, 16384, -32768, 0, 16384);
    drain();

    // sweeps over several link settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_links(0, 0, 0, 0, 0);
        1: write_links(LenMax, LenMax, LenMax, LenMax, LenMax);
        5: write_links(17024, 85965, 46848, 14080, 17920);
        default: write_links($urandom_range(0, LenMax), $urandom_range(0, LenMax),
                             $urandom_range(0, LenMax), $urandom_range(0, LenMax),
                             $urandom_range(0, LenMax));
      endcase
      gaps_on = (ph != 3);
      queue_random(255);
      if (ph == 2) begin
        // stop sending mid-phase until the pipeline has emptied
        wait (pending_sets.size() < 128);
        hold_req = 1'b1;
        wait (expected_poses.size() == 0);
        hold_req = 1'b0;
      end
      drain();
    end

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fkp_pkg.sv
hw/rtl/fkp_rot_cell.sv
hw/rtl/fkp_vec_cell.sv
hw/rtl/fkp_sqrt_cell.sv
hw/rtl/fkp_joint_cell.sv
hw/rtl/forward_kinematics_5dof_pose.sv
hw/rtl/fkp_checker.sv
dv/forward_kinematics_5dof_pose_tb.sv
